// ----- rtl/core/tunnel_address_lease_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tunnel address lease allocator
// Clocked, reset-qualified property wrappers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef TUNNEL_ADDRESS_LEASE_ALLOCATOR_MACROS_SVH
`define TUNNEL_ADDRESS_LEASE_ALLOCATOR_MACROS_SVH

// Property must hold at every clock edge out of reset
`define TALLA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen out of reset
`define TALLA_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/talla_pkg.sv -----
// ----------------------------------------------------------------------------
// talla_pkg
// Shared types and constants of the tunnel address lease allocator.
// ----------------------------------------------------------------------------
package talla_pkg;

  localparam int LEASE_ENTRIES     = 256;
  localparam int IDX_W             = $clog2(LEASE_ENTRIES);
  localparam int CNT_W             = IDX_W + 1;
  localparam int FIRST_SCAN_OFFSET = 100;
  localparam int TOP_OFFSET        = 255;
  localparam int SCAN_LEN          = TOP_OFFSET - FIRST_SCAN_OFFSET;

  // request codes
  localparam logic [1:0] REQ_RESERVE = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RECORD  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // one lease table word
  typedef struct packed {
    logic [63:0] dev_hi;
    logic [63:0] dev_lo;
    logic [7:0]  off;
    logic [31:0] seen;
    logic        act;
  } lease_t;

  // compare unit results
  typedef struct packed {
    logic match;
    logic cand;
    logic older;
  } cmp_res_t;

endpackage

// ----- rtl/core/talla_cmp.sv -----
// ----------------------------------------------------------------------------
// talla_cmp
// Shared compare unit: identity match and eviction candidate / age order.
// ----------------------------------------------------------------------------
module talla_cmp import talla_pkg::*; (
  input  lease_t      entry,
  input  logic        entry_valid,
  input  logic        entry_in_use,
  input  logic [63:0] key_hi,
  input  logic [63:0] key_lo,
  input  logic [31:0] best_seen,
  input  logic [63:0] best_hi,
  input  logic [63:0] best_lo,
  output cmp_res_t    res
);

  logic older_w;

  // identity match
  assign res.match = entry_valid && (entry.dev_hi == key_hi) && (entry.dev_lo == key_lo);

  // inactive lease inside the scan range whose address is free
  assign res.cand = entry_valid && !entry.act &&
                    (entry.off >= 8'(FIRST_SCAN_OFFSET)) &&
                    (entry.off < 8'(TOP_OFFSET)) && !entry_in_use;

  // age order, ties broken by smaller identifier
  always_comb begin
    if (entry.seen != best_seen) begin
      older_w = entry.seen < best_seen;
    end else if (entry.dev_hi != best_hi) begin
      older_w = entry.dev_hi < best_hi;
    end else begin
      older_w = entry.dev_lo < best_lo;
    end
  end

  assign res.older = older_w;

endmodule

// ----- rtl/core/tunnel_address_lease_allocator.sv -----
// ----------------------------------------------------------------------------
// tunnel_address_lease_allocator
// Address pool allocator with sticky device leases, run by a sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time. A request that needs the lease table walks all
// entries through the single read port of the lease memory, one entry per
// cycle; a reserve may add a round-robin scan of up to 155 offsets and a
// second walk for the oldest inactive lease. The result is held in an output
// register; the next request is taken once the sequencer is back in idle. No
// clearing pass is needed after reset.
`include "tunnel_address_lease_allocator_macros.svh"

module tunnel_address_lease_allocator import talla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic        in_has_device,
  input  logic [63:0] in_device_id_high,
  input  logic [63:0] in_device_id_low,
  input  logic [31:0] in_address,
  input  logic        in_lease_active,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_assigned_address,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_START   = 8'b0000_0010,
    S_WALK    = 8'b0000_0100,
    S_FDONE   = 8'b0000_1000,
    S_DESIRED = 8'b0001_0000,
    S_SCAN    = 8'b0010_0000,
    S_EVICT   = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_t;

  state_t state_r;

  // configuration and maps
  logic [23:0] prefix_r;
  logic [255:0] in_use_r, leased_r;
  logic [LEASE_ENTRIES-1:0] valid_r;
  logic [7:0] scan_ptr_r;

  // latched request
  logic [1:0]  typ_r;
  logic        dev_r, act_r;
  logic [63:0] hi_r, lo_r;
  logic [31:0] addr_r, now_r;

  // walk control
  logic [CNT_W-1:0] idx_r;
  logic             pend_r, walk_old_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             hit_r, free_r, best_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, best_idx_r;
  logic [7:0]       hit_off_r, best_off_r;
  logic [31:0]      best_seen_r;
  logic [63:0]      best_hi_r, best_lo_r;
  logic [7:0]       scan_cnt_r;

  // result
  logic [31:0] res_addr_r;
  logic [1:0]  res_stat_r;
  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [1:0]  out_stat_r;

  // lease memory
  lease_t           mem [LEASE_ENTRIES];
  lease_t           mem_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  lease_t           mem_wd;

  cmp_res_t   cmp;
  logic       in_pool;
  logic [7:0] scan_nxt;
  logic       walk_end;

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_assigned_address = out_addr_r;
  assign out_status           = out_stat_r;

  assign in_pool  = (addr_r[31:8] == prefix_r);
  assign scan_nxt = ((scan_ptr_r + 8'd1) >= 8'(TOP_OFFSET)) ? 8'(FIRST_SCAN_OFFSET)
                                                            : scan_ptr_r + 8'd1;
  assign walk_end = (idx_r == CNT_W'(LEASE_ENTRIES)) && !pend_r;

  // shared compare unit
  talla_cmp u_cmp (
    .entry       (mem_q),
    .entry_valid (valid_r[pend_idx_r]),
    .entry_in_use(in_use_r[mem_q.off]),
    .key_hi      (hi_r),
    .key_lo      (lo_r),
    .best_seen   (best_seen_r),
    .best_hi     (best_hi_r),
    .best_lo     (best_lo_r),
    .res         (cmp)
  );

  // lease memory write after a find walk
  always_comb begin
    mem_we = 1'b0;
    mem_wa = hit_idx_r;
    mem_wd = '{dev_hi: hi_r, dev_lo: lo_r, off: addr_r[7:0], seen: now_r, act: act_r};
    if (state_r == S_FDONE) begin
      if (typ_r == REQ_RELEASE) begin
        mem_we    = hit_r && (hit_off_r == addr_r[7:0]);
        mem_wd.off = hit_off_r;
        mem_wd.act = 1'b0;
      end else if (typ_r == REQ_RECORD) begin
        mem_we = hit_r || free_r;
        mem_wa = hit_r ? hit_idx_r : free_idx_r;
      end
    end
  end

  // memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[idx_r[IDX_W-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prefix_r    <= '0;
      in_use_r    <= '0;
      leased_r    <= '0;
      valid_r     <= '0;
      scan_ptr_r  <= 8'(FIRST_SCAN_OFFSET - 1);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prefix_r <= cfg_wr_data;
      end
      // result taken; a new one from S_RESP replaces it below
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            typ_r   <= in_req_type;
            dev_r   <= in_has_device;
            hi_r    <= in_device_id_high;
            lo_r    <= in_device_id_low;
            addr_r  <= in_address;
            act_r   <= in_lease_active;
            now_r   <= in_now_seconds;
            state_r <= S_START;
          end
        end

        S_START: begin
          res_addr_r <= '0;
          res_stat_r <= ST_OK;
          idx_r      <= '0;
          pend_r     <= 1'b0;
          walk_old_r <= 1'b0;
          hit_r      <= 1'b0;
          free_r     <= 1'b0;
          best_r     <= 1'b0;
          unique case (typ_r)
            REQ_RESERVE: state_r <= dev_r ? S_WALK : S_DESIRED;
            REQ_RELEASE: begin
              if (in_pool) begin
                in_use_r[addr_r[7:0]] <= 1'b0;
              end
              state_r <= (in_pool && dev_r) ? S_WALK : S_RESP;
            end
            REQ_RECORD: state_r <= (in_pool && dev_r) ? S_WALK : S_RESP;
            default: state_r <= S_RESP;
          endcase
        end

        // one entry issued and one compared per cycle
        S_WALK: begin
          if (idx_r != CNT_W'(LEASE_ENTRIES)) begin
            pend_r     <= 1'b1;
            pend_idx_r <= idx_r[IDX_W-1:0];
            idx_r      <= idx_r + CNT_W'(1);
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            if (!walk_old_r) begin
              if (cmp.match && !hit_r) begin
                hit_r     <= 1'b1;
                hit_idx_r <= pend_idx_r;
                hit_off_r <= mem_q.off;
              end
              if (!valid_r[pend_idx_r] && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= pend_idx_r;
              end
            end else if (cmp.cand && (!best_r || cmp.older)) begin
              best_r      <= 1'b1;
              best_idx_r  <= pend_idx_r;
              best_off_r  <= mem_q.off;
              best_seen_r <= mem_q.seen;
              best_hi_r   <= mem_q.dev_hi;
              best_lo_r   <= mem_q.dev_lo;
            end
          end
          if (walk_end) begin
            state_r <= walk_old_r ? S_EVICT : S_FDONE;
          end
        end

        S_FDONE: begin
          unique case (typ_r)
            REQ_RESERVE: begin
              if (hit_r && !in_use_r[hit_off_r]) begin
                in_use_r[hit_off_r] <= 1'b1;
                res_addr_r          <= {prefix_r, hit_off_r};
                // a lease at the all-zero address reads as no address
                if ({prefix_r, hit_off_r} == 32'd0) begin
                  res_stat_r <= ST_EXHAUSTED;
                end
                state_r <= S_RESP;
              end else begin
                state_r <= S_DESIRED;
              end
            end
            REQ_RECORD: begin
              state_r <= S_RESP;
              if (hit_r) begin
                if (({prefix_r, hit_off_r} != 32'd0) && ({prefix_r, hit_off_r} != addr_r)) begin
                  leased_r[hit_off_r] <= 1'b0;
                end
                leased_r[addr_r[7:0]] <= 1'b1;
              end else if (free_r) begin
                valid_r[free_idx_r]   <= 1'b1;
                leased_r[addr_r[7:0]] <= 1'b1;
              end else begin
                res_stat_r <= ST_FULL;
              end
            end
            default: state_r <= S_RESP;
          endcase
        end

        // requested address
        S_DESIRED: begin
          scan_cnt_r <= '0;
          if (in_pool && (addr_r[7:0] > 8'd1) && (addr_r[7:0] < 8'(TOP_OFFSET)) &&
              !in_use_r[addr_r[7:0]] && !leased_r[addr_r[7:0]]) begin
            in_use_r[addr_r[7:0]] <= 1'b1;
            res_addr_r            <= addr_r;
            state_r               <= S_RESP;
          end else begin
            state_r <= S_SCAN;
          end
        end

        // round-robin scan, one offset per cycle
        S_SCAN: begin
          scan_ptr_r <= scan_nxt;
          scan_cnt_r <= scan_cnt_r + 8'd1;
          if (!in_use_r[scan_nxt] && !leased_r[scan_nxt]) begin
            in_use_r[scan_nxt] <= 1'b1;
            res_addr_r         <= {prefix_r, scan_nxt};
            state_r            <= S_RESP;
          end else if (scan_cnt_r == 8'(SCAN_LEN - 1)) begin
            idx_r      <= '0;
            pend_r     <= 1'b0;
            walk_old_r <= 1'b1;
            best_r     <= 1'b0;
            state_r    <= S_WALK;
          end
        end

        S_EVICT: begin
          if (best_r) begin
            leased_r[best_off_r] <= 1'b0;
            valid_r[best_idx_r]  <= 1'b0;
            in_use_r[best_off_r] <= 1'b1;
            res_addr_r           <= {prefix_r, best_off_r};
          end else begin
            res_stat_r <= ST_EXHAUSTED;
          end
          state_r <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_addr_r  <= res_addr_r;
            out_stat_r  <= res_stat_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  `TALLA_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `TALLA_NEVER(a_exhausted_zero, out_valid && (out_status == ST_EXHAUSTED) && (out_assigned_address != 32'd0), "exhausted with address")
  `TALLA_ASSERT(a_state_onehot, $onehot(state_r), "state not one-hot")

endmodule
